>>> src/modular_arithmetic_unit_top_macros.svh
// assertion macros shared by the checker of the modular arithmetic unit
// expects clk and rst in the scope where a macro is used
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define MAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mau assertion failed");

// next-cycle implication, off during reset
`define MAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mau assertion failed");

`endif

>>> src/mau_pkg.sv
`timescale 1ns / 1ps
// types and constants of the modular arithmetic unit
// no dependencies
package mau_pkg;

  localparam int EXP_WIDTH = 63;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // word index of the modulus register on the config port
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_POW = 2'd1,
    OP_INV = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINAL,
    ST_DONE
  } state_t;

endpackage

>>> src/modular_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// modular arithmetic unit: multiply, power, inverse and divide modulo a
// configurable modulus, all through one bit-serial modular multiplier
// depends on mau_pkg
//
// usage: write the modulus over the apb port (byte address 0) while idle.
// drive req_type, operand_a, operand_b, exponent and pulse start while busy
// is low; the item is taken at that edge and busy rises. when the item is
// finished, result is shown with done high for one cycle, then busy drops.
// the receiver cannot stall: result must be taken in the done cycle.
// sequence, from the accepting edge to the done cycle: every modular
// multiply is bit-serial, one multiplier bit per cycle (W = OPERAND_WIDTH
// bits). multiply: reduce a, then multiply by b. power: reduce the base,
// then for each exponent bit, lowest first, multiply the accumulator by
// the square when the bit is one, then square; inverse (of a) and divide
// (power of b, then times a) run the power with exponent m-2.
// a modulus below 2 gives result 0 in the cycle after the accepting edge.
// busy drops in the cycle after done; a new item is taken only while idle.
// reset: synchronous; modulus returns to 1000000007 (low W bits), block idle.
module modular_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [OPERAND_WIDTH-1:0]        operand_a,
  input  logic [OPERAND_WIDTH-1:0]        operand_b,
  input  logic [mau_pkg::EXP_WIDTH-1:0]   exponent,
  output logic                            done,
  output logic [OPERAND_WIDTH-1:0]        result
);
  import mau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_MAX = CW'(W - 1);

  state_t               state, state_next;
  op_t                  op;
  logic [W-1:0]         modulus;
  logic [W-1:0]         opa, opb;
  logic [EXP_WIDTH-1:0] e;
  logic [W-1:0]         sq, acc, res;
  logic [W-1:0]         mx, my, macc;
  logic [CW-1:0]        cnt;

  logic                 m_small;
  logic                 mm_last;
  logic [W+1:0]         t, m1, m2;
  logic [W-1:0]         mm_val;
  logic                 cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MODULUS) ? 32'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(MODULUS_RESET);
    end else if (cfg_wr && paddr[2] == REG_MODULUS) begin
      modulus <= pwdata[W-1:0];
    end
  end

  assign m_small = (modulus[W-1:1] == '0);

  // interleaved modular multiply step: macc = (2*macc + bit*mx) mod m
  // mx and macc stay below m, so at most two subtractions of m are needed
  assign m1 = {2'b00, modulus};
  assign m2 = {1'b0, modulus, 1'b0};
  assign t  = {1'b0, macc, 1'b0} + {2'b00, (my[W-1] ? mx : {W{1'b0}})};

  always_comb begin
    if (t >= m2) begin
      mm_val = W'(t - m2);
    end else if (t >= m1) begin
      mm_val = W'(t - m1);
    end else begin
      mm_val = W'(t);
    end
  end

  assign mm_last = (cnt == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = m_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_last) begin
          state_next = (op == OP_MUL) ? ST_FINAL : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (e == '0) begin
          state_next = (op == OP_DIV) ? ST_FINAL : ST_DONE;
        end else if (e[0]) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_last) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINAL: begin
        if (mm_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath; a later load overrides the running multiply step
  always_ff @(posedge clk) begin
    if (state == ST_REDUCE || state == ST_MUL || state == ST_SQR ||
        state == ST_FINAL) begin
      macc <= mm_val;
      my   <= my << 1;
      cnt  <= cnt - 1'b1;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          op   <= op_t'(req_type);
          opa  <= operand_a;
          opb  <= operand_b;
          e    <= (op_t'(req_type) == OP_POW) ? exponent
                                              : EXP_WIDTH'(modulus - W'(2));
          // reduce the base first: 1 * base mod m
          mx   <= W'(1);
          my   <= (op_t'(req_type) == OP_DIV) ? operand_b : operand_a;
          macc <= '0;
          cnt  <= CNT_MAX;
          res  <= '0;
        end
      end
      ST_REDUCE: begin
        if (mm_last) begin
          sq   <= mm_val;
          acc  <= W'(1);
          mx   <= mm_val;
          my   <= opb;
          macc <= '0;
          cnt  <= CNT_MAX;
        end
      end
      ST_CHECK: begin
        macc <= '0;
        cnt  <= CNT_MAX;
        if (e == '0) begin
          res <= acc;
          mx  <= acc;
          my  <= opa;
        end else if (e[0]) begin
          mx <= acc;
          my <= sq;
        end else begin
          mx <= sq;
          my <= sq;
        end
      end
      ST_MUL: begin
        if (mm_last) begin
          acc  <= mm_val;
          mx   <= sq;
          my   <= sq;
          macc <= '0;
          cnt  <= CNT_MAX;
        end
      end
      ST_SQR: begin
        if (mm_last) begin
          sq <= mm_val;
          e  <= e >> 1;
        end
      end
      ST_FINAL: begin
        if (mm_last) begin
          res <= mm_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/mau_chk.sv
`timescale 1ns / 1ps
// port-level checker for the modular arithmetic unit, bound to the top level
// depends on modular_arithmetic_unit_top_macros.svh
`include "modular_arithmetic_unit_top_macros.svh"

module mau_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted item keeps the block busy
  `MAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the result strobe only comes while an item is in flight
  `MAU_ASSERT_NOW(a_done_busy, done, busy)
  // after the result the block is free again
  `MAU_ASSERT_NEXT(a_done_free, done, !busy && !done)
  // no result without an item
  `MAU_ASSERT_NEXT(a_no_spurious, !busy && !start, !done)

endmodule

bind modular_arithmetic_unit_top mau_chk u_mau_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

>>> tb/sv/modular_result_checker.sv
`timescale 1ns / 1ps
// result checker for the modular arithmetic unit: tracks the modulus written
// over apb, predicts each item's result and compares it with the done strobe
// depends on mau_pkg
module modular_result_checker #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [OPERAND_WIDTH-1:0]      operand_a,
  input  logic [OPERAND_WIDTH-1:0]      operand_b,
  input  logic [mau_pkg::EXP_WIDTH-1:0] exponent,
  input  logic                          done,
  input  logic [OPERAND_WIDTH-1:0]      result,
  output int                            mismatches,
  output int                            pending
);
  import mau_pkg::*;

  typedef logic [OPERAND_WIDTH-1:0] word_t;
  typedef longint unsigned u64_t;

  word_t modulus_q;
  word_t expected_results[$];

  // both factors are below 2^31, so the 64-bit product is exact
  function automatic u64_t mulmod(u64_t x, u64_t y, u64_t m);
    return (x * y) % m;
  endfunction

  // right-to-left square and multiply
  function automatic u64_t powmod(u64_t base, u64_t e, u64_t m);
    u64_t acc;
    u64_t sq;
    acc = 64'd1 % m;
    sq = base % m;
    e = e & 64'h7FFF_FFFF_FFFF_FFFF;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic word_t predicted_result(op_t op, word_t a_in, word_t b_in,
                                             logic [EXP_WIDTH-1:0] e, word_t m_in);
    u64_t m;
    u64_t a;
    u64_t b;
    u64_t r;
    m = u64_t'(m_in);
    if (m == 0) return '0;
    a = u64_t'(a_in) % m;
    b = u64_t'(b_in) % m;
    case (op)
      OP_MUL: r = mulmod(a, b, m);
      OP_POW: r = powmod(a, u64_t'(e), m);
      // fermat inverse; a modulus of one leaves nothing to raise
      OP_INV: r = (m >= 2) ? powmod(a, m - 2, m) : 64'd0;
      default: r = (m >= 2) ? mulmod(a, powmod(b, m - 2, m), m) : 64'd0;
    endcase
    return word_t'(r);
  endfunction

  always @(posedge clk) begin : watch
    word_t want;
    if (rst) begin
      modulus_q <= MODULUS_RESET[OPERAND_WIDTH-1:0];
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_MODULUS, 2'b00})
        modulus_q <= pwdata[OPERAND_WIDTH-1:0];
      if (start && !busy)
        expected_results = {expected_results,
                            predicted_result(op_t'(req_type), operand_a, operand_b,
                                             exponent, modulus_q)};
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with no item outstanding", result);
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %0d, got %0d (modulus %0d)",
                       want, result, modulus_q);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/tb_modular_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// testbench top for the modular arithmetic unit: drives apb modulus writes
// and items, checking is done by modular_result_checker
// depends on mau_pkg, modular_arithmetic_unit_top and modular_result_checker
module tb_modular_arithmetic_unit_top;
  import mau_pkg::*;

  localparam int W = 31;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef logic [W-1:0] word_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_type;
  word_t                operand_a;
  word_t                operand_b;
  logic [EXP_WIDTH-1:0] exponent;
  logic                 done;
  word_t                result;

  int    mismatches;
  int    pending;
  int    cycle_count;
  word_t cur_modulus;
  bit    allow_gaps;

  modular_arithmetic_unit_top #(
    .OPERAND_WIDTH(W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .exponent(exponent),
    .done(done),
    .result(result)
  );

  modular_result_checker #(
    .OPERAND_WIDTH(W)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .exponent(exponent),
    .done(done),
    .result(result),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[modular_arithmetic_unit_top] ERROR");
      $finish;
    end
  end

  // start may stay high across items; it only drops for an idle burst
  task automatic send_item(op_t op, word_t a, word_t b, logic [EXP_WIDTH-1:0] e);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    exponent <= e;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_modulus(logic [31:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MODULUS, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_modulus = value[W-1:0];
  endtask

  // operands lean toward zero, one, m-1, m and all ones
  function automatic word_t pick_operand(word_t m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return word_t'(1);
      2: return m - 1'b1;
      3: return m;
      4: return '1;
      5, 6: return (m == 0) ? '0 : word_t'($urandom_range(0, m - 1));
      default: return word_t'($urandom);
    endcase
  endfunction

  // mostly short exponents to keep the run short, a few full width
  function automatic logic [EXP_WIDTH-1:0] pick_exponent();
    int r;
    int bits;
    logic [63:0] raw;
    r = $urandom_range(0, 9);
    bits = (r < 6) ? $urandom_range(0, 12) : (r < 9) ? $urandom_range(13, 40) : EXP_WIDTH;
    raw = {$urandom, $urandom};
    raw = raw & ((64'd1 << bits) - 1);
    return raw[EXP_WIDTH-1:0];
  endfunction

  task automatic run_random(int count);
    repeat (count)
      send_item(op_t'($urandom_range(0, 3)), pick_operand(cur_modulus),
                pick_operand(cur_modulus), pick_exponent());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    req_type = OP_MUL;
    operand_a = '0;
    operand_b = '0;
    exponent = '0;
    allow_gaps = 1'b1;
    cur_modulus = MODULUS_RESET[W-1:0];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset modulus, extremes of every operation
    send_item(OP_MUL, '0, '0, '1);
    send_item(OP_MUL, '1, '1, '0);
    send_item(OP_MUL, cur_modulus - 1'b1, cur_modulus - 1'b1, 63'd12345);
    send_item(OP_MUL, cur_modulus, word_t'(5), '0);
    send_item(OP_POW, word_t'(2), '1, '0);
    send_item(OP_POW, '0, '0, '0);
    send_item(OP_POW, '1, '0, '1);
    send_item(OP_POW, word_t'(3), word_t'(77), 63'd1);
    send_item(OP_POW, '0, '1, 63'd5);
    send_item(OP_POW, word_t'(2), '0, 63'h4000_0000_0000_0000);
    send_item(OP_INV, '0, '1, '1);
    send_item(OP_INV, word_t'(1), '0, '0);
    send_item(OP_INV, '1, '0, '0);
    send_item(OP_INV, cur_modulus - 1'b1, '0, '0);
    send_item(OP_DIV, word_t'(7), '0, '0);
    send_item(OP_DIV, '1, cur_modulus, '1);
    send_item(OP_DIV, '0, word_t'(3), '0);
    send_item(OP_DIV, '1, '1, '0);
    send_item(OP_DIV, cur_modulus - 1'b1, word_t'(2), '0);

    // largest prime, smallest modulus, small and composite moduli
    write_modulus(32'h7FFF_FFFF);
    run_random(45);
    allow_gaps = ($urandom_range(0, 3) != 0);
    write_modulus(32'd2);
    run_random(40);
    allow_gaps = ($urandom_range(0, 3) != 0);
    write_modulus(32'd13);
    run_random(40);
    allow_gaps = ($urandom_range(0, 3) != 0);
    write_modulus(32'd1000);
    run_random(40);
    // the top data bit is not part of the modulus
    allow_gaps = 1'b1;
    write_modulus(32'h8000_0011);
    run_random(30);
    // degenerate moduli give zero for everything
    write_modulus(32'd0);
    run_random(10);
    write_modulus(32'd1);
    run_random(10);
    write_modulus($urandom_range(2, 32'h7FFF_FFFF));
    run_random(45);
    allow_gaps = ($urandom_range(0, 3) != 0);
    write_modulus($urandom_range(2, 32'h7FFF_FFFF));
    run_random(45);
    write_modulus(32'd65537);
    run_random(40);

    allow_gaps = 1'b0;
    write_modulus(MODULUS_RESET);
    run_random(40);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("[modular_arithmetic_unit_top] OK");
    end else begin
      $display("[modular_arithmetic_unit_top] ERROR");
    end
    $finish;
  end

endmodule
